[design/sparse_matrix_transpose_unit_defines.svh]
// Assertion helpers for the sparse matrix transpose unit.
// Both expect signals named clock and reset in the using scope.
`ifndef SPARSE_MATRIX_TRANSPOSE_UNIT_DEFINES_SVH
`define SPARSE_MATRIX_TRANSPOSE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SMTU_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error(msg);

// Next-cycle implication.
`define SMTU_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error(msg);

`endif

[design/smtu_pkg.sv]
`timescale 1ns / 1ps

package smtu_pkg;

   localparam int MAX_TERMS     = 64;
   localparam int TERM_IDX_BITS = $clog2(MAX_TERMS);
   localparam int TERM_CNT_BITS = TERM_IDX_BITS + 1;
   localparam int MAX_DIM       = 256;
   localparam int COL_BITS      = $clog2(MAX_DIM);
   localparam int CFG_BITS      = 9;
   localparam int VALUE_BITS    = 32;
   localparam int CNT_BITS      = 7;

   localparam logic [CFG_BITS-1:0] NUM_COLS_RESET = CFG_BITS'(256);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INC,
      ST_PREFIX,
      ST_LOOK,
      ST_WRITE,
      ST_EMIT
   } st_type;

   // One stored triplet; also the layout of a transposed slot.
   typedef struct packed {
      logic [COL_BITS-1:0]          row;
      logic [COL_BITS-1:0]          col;
      logic signed [VALUE_BITS-1:0] value;
   } term_type;

   // Control word into the column count memory.
   typedef struct packed {
      logic [COL_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [COL_BITS-1:0] wr_addr;
      logic [CNT_BITS-1:0] wr_data;
      logic                clear;
   } cnt_req_type;

endpackage

[design/sparse_matrix_transpose_unit.sv]
// Load: a dropped term is taken in ST_IDLE alone; a stored term also passes ST_INC (busy).
// On the last term: column prefix walk (ST_PREFIX), scatter of each stored term
// (ST_LOOK then ST_WRITE), then 1 word per cycle out (ST_EMIT).
// Reset (synchronous, active high) clears state, counts and drop flag; num_cols reads 256.
// Results are strobed once on rsp_valid; the receiver cannot stall.
`timescale 1ns / 1ps
`include "sparse_matrix_transpose_unit_defines.svh"

module sparse_matrix_transpose_unit
   import smtu_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // term input (command style)
   input  logic                         start,
   output logic                         busy,
   input  logic [COL_BITS-1:0]          req_term_row,
   input  logic [COL_BITS-1:0]          req_term_col,
   input  logic signed [VALUE_BITS-1:0] req_term_value,
   input  logic                         req_last_term,
   // result strobe
   output logic                         rsp_valid,
   output logic [COL_BITS-1:0]          rsp_out_row,
   output logic [COL_BITS-1:0]          rsp_out_col,
   output logic signed [VALUE_BITS-1:0] rsp_out_value,
   output logic                         rsp_out_last,
   output logic                         rsp_dropped_flag,
   // configuration
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CFG_BITS-1:0]          csr_num_cols
);

   st_type                   state_ff, state_in;
   logic [CFG_BITS-1:0]      num_cols_ff;
   logic [TERM_CNT_BITS-1:0] term_count_ff, term_count_in;
   logic                     drop_seen_ff, drop_seen_in;
   logic                     last_ff, last_in;
   logic [COL_BITS-1:0]      pend_col_ff, pend_col_in;
   logic [CFG_BITS-1:0]      walk_ff, walk_in;      // prefix walk column, 0..MAX_DIM (MAX_DIM+1 once the walk ends)
   logic [CNT_BITS-1:0]      sum_ff, sum_in;        // running exclusive prefix sum
   logic [TERM_IDX_BITS-1:0] idx_ff, idx_in;        // scatter / emit term index
   logic                     emit_v_ff, emit_last_ff, emit_drop_ff;

   logic [CFG_BITS-1:0]      col_lim;
   logic [CFG_BITS-1:0]      prev_col;
   logic                     accept;
   logic                     store_ok;
   logic                     idx_last;
   logic                     walk_done;
   logic                     clear;

   // shared adder: count+1 on load, prefix accumulate, start+1 on scatter
   logic [CNT_BITS-1:0]      add_a, add_b, add_sum;

   cnt_req_type              cnt_req;
   logic [CNT_BITS-1:0]      cnt_rd;

   logic                     term_wr_en;
   term_type                 term_wr, term_rd;
   logic                     slot_wr_en;
   logic [TERM_IDX_BITS-1:0] slot_wr_addr, slot_rd_addr;
   term_type                 slot_wr, slot_rd;

   // ---------------------------------------------------------------
   // Handshake and decode
   // ---------------------------------------------------------------
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign accept    = start && !busy;

   // num_cols above the column space acts as the full space
   assign col_lim  = (num_cols_ff > CFG_BITS'(MAX_DIM)) ? CFG_BITS'(MAX_DIM) : num_cols_ff;
   assign store_ok = (term_count_ff < TERM_CNT_BITS'(MAX_TERMS)) &&
                     ({1'b0, req_term_col} < col_lim);

   assign prev_col  = walk_ff - CFG_BITS'(1);
   assign walk_done = (walk_ff == CFG_BITS'(MAX_DIM));
   assign idx_last  = ({1'b0, idx_ff} + TERM_CNT_BITS'(1)) == term_count_ff;

   assign add_sum = add_a + add_b;

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (store_ok) begin
                  state_in = ST_INC;
               end else if (req_last_term) begin
                  state_in = ST_PREFIX;
               end
            end
         end
         ST_INC: begin
            state_in = last_ff ? ST_PREFIX : ST_IDLE;
         end
         ST_PREFIX: begin
            if (walk_done) begin
               // a matrix that lost all its terms yields nothing
               state_in = (term_count_ff == '0) ? ST_IDLE : ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = idx_last ? ST_EMIT : ST_LOOK;
         end
         ST_EMIT: begin
            if (idx_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Datapath and memory control
   // ---------------------------------------------------------------
   always_comb begin
      term_count_in = term_count_ff;
      drop_seen_in  = drop_seen_ff;
      last_in       = last_ff;
      pend_col_in   = pend_col_ff;
      walk_in       = walk_ff;
      sum_in        = sum_ff;
      idx_in        = idx_ff;
      clear         = 1'b0;
      add_a         = '0;
      add_b         = '0;
      cnt_req       = '0;
      term_wr_en    = 1'b0;
      term_wr       = '{row: req_term_row, col: req_term_col, value: req_term_value};
      slot_wr_en    = 1'b0;
      slot_wr_addr  = cnt_rd[TERM_IDX_BITS-1:0];
      slot_wr       = '{row: term_rd.col, col: term_rd.row, value: term_rd.value};
      slot_rd_addr  = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            walk_in = '0;
            sum_in  = '0;
            idx_in  = '0;
            if (accept) begin
               last_in          = req_last_term;
               pend_col_in      = req_term_col;
               cnt_req.rd_addr  = req_term_col;
               if (store_ok) begin
                  term_wr_en    = 1'b1;
                  term_count_in = term_count_ff + TERM_CNT_BITS'(1);
               end else begin
                  drop_seen_in  = 1'b1;
               end
            end
         end
         ST_INC: begin
            // bump this column's count
            add_a           = cnt_rd;
            add_b           = CNT_BITS'(1);
            cnt_req.wr_en   = 1'b1;
            cnt_req.wr_addr = pend_col_ff;
            cnt_req.wr_data = add_sum;
         end
         ST_PREFIX: begin
            // read column walk, turn the previous column's count into its start
            cnt_req.rd_addr = walk_ff[COL_BITS-1:0];
            walk_in         = walk_ff + CFG_BITS'(1);
            if (walk_ff != '0) begin
               add_a           = sum_ff;
               add_b           = (prev_col < col_lim) ? cnt_rd : '0;
               sum_in          = add_sum;
               cnt_req.wr_en   = 1'b1;
               cnt_req.wr_addr = prev_col[COL_BITS-1:0];
               cnt_req.wr_data = sum_ff;
            end
            if (walk_done && (term_count_ff == '0)) begin
               clear = 1'b1;
            end
         end
         ST_LOOK: begin
            cnt_req.rd_addr = term_rd.col;
         end
         ST_WRITE: begin
            // place term at its column start, advance that start
            slot_wr_en      = 1'b1;
            add_a           = cnt_rd;
            add_b           = CNT_BITS'(1);
            cnt_req.wr_en   = 1'b1;
            cnt_req.wr_addr = term_rd.col;
            cnt_req.wr_data = add_sum;
            idx_in          = idx_last ? '0 : idx_ff + TERM_IDX_BITS'(1);
         end
         ST_EMIT: begin
            idx_in = idx_ff + TERM_IDX_BITS'(1);
            if (idx_last) begin
               clear  = 1'b1;
               idx_in = '0;
            end
         end
         default: begin
         end
      endcase

      if (clear) begin
         cnt_req.clear = 1'b1;
         term_count_in = '0;
         drop_seen_in  = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_cols_ff   <= NUM_COLS_RESET;
         term_count_ff <= '0;
         drop_seen_ff  <= 1'b0;
         last_ff       <= 1'b0;
         walk_ff       <= '0;
         sum_ff        <= '0;
         idx_ff        <= '0;
         emit_v_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         term_count_ff <= term_count_in;
         drop_seen_ff  <= drop_seen_in;
         last_ff       <= last_in;
         walk_ff       <= walk_in;
         sum_ff        <= sum_in;
         idx_ff        <= idx_in;
         emit_v_ff     <= (state_ff == ST_EMIT);
         if (csr_valid && csr_ready) begin
            num_cols_ff <= csr_num_cols;
         end
      end
   end

   // payload side, lines up with the registered slot read
   always_ff @(posedge clock) begin
      pend_col_ff  <= pend_col_in;
      emit_last_ff <= idx_last;
      emit_drop_ff <= drop_seen_ff;
   end

   // ---------------------------------------------------------------
   // Storage
   // ---------------------------------------------------------------
   // Term read address follows the next index so data matches idx_ff.
   smtu_ram #(
      .WIDTH ($bits(term_type)),
      .DEPTH (MAX_TERMS)
   ) u_term_ram (
      .clock   (clock),
      .wr_en   (term_wr_en),
      .wr_addr (term_count_ff[TERM_IDX_BITS-1:0]),
      .wr_data (term_wr),
      .rd_addr (idx_in),
      .rd_data (term_rd)
   );

   smtu_ram #(
      .WIDTH ($bits(term_type)),
      .DEPTH (MAX_TERMS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd)
   );

   smtu_cnt_mem u_cnt_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (cnt_req),
      .rd_data (cnt_rd)
   );

   // ---------------------------------------------------------------
   // Result word
   // ---------------------------------------------------------------
   assign rsp_valid        = emit_v_ff;
   assign rsp_out_row      = slot_rd.row;
   assign rsp_out_col      = slot_rd.col;
   assign rsp_out_value    = slot_rd.value;
   assign rsp_out_last     = emit_last_ff;
   assign rsp_dropped_flag = emit_drop_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `SMTU_ASSERT_NOW(a_cnt_bound, 1'b1, term_count_ff <= TERM_CNT_BITS'(MAX_TERMS), "term count past capacity")
   `SMTU_ASSERT_NEXT(a_last_busy, accept && req_last_term, busy, "last term did not start transpose")
   `SMTU_ASSERT_NEXT(a_one_last, rsp_valid && rsp_out_last, !rsp_valid, "word after last word")
   `SMTU_ASSERT_NOW(a_emit_idx, state_ff == ST_EMIT, ({1'b0, idx_ff} < term_count_ff), "emit past term count")
   `SMTU_ASSERT_NEXT(a_clear, clear, (term_count_ff == '0) && !drop_seen_ff, "matrix state not cleared")

endmodule

[design/smtu_ram.sv]
`timescale 1ns / 1ps

module smtu_ram #(
   parameter int  WIDTH = 48,
   parameter int  DEPTH = 64,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/smtu_cnt_mem.sv]
`timescale 1ns / 1ps

module smtu_cnt_mem
   import smtu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cnt_req_type         req,
   output logic [CNT_BITS-1:0] rd_data
);

   logic [CNT_BITS-1:0] mem_ff [MAX_DIM];
   logic [MAX_DIM-1:0]  valid_ff;
   logic [CNT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      rd_data_ff <= valid_ff[req.rd_addr] ? mem_ff[req.rd_addr] : '0;
   end

   // invalid entry reads as zero count
   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

// Bench for the sparse matrix transpose unit.
// Terms go in over the start/busy handshake, each transposed word comes back
// on a one-cycle rsp_valid strobe. A local model of the unit tracks the
// stored terms, the column tallies and the drop flag, and queues the words
// each last term should produce. A monitor pops one word per strobe.
module tb_top;
   import smtu_pkg::*;

   localparam int HALF_PERIOD    = 6;
   // Settle time after the queue drains: covers the prefix walk of a matrix whose
   // terms all dropped, plus the count clear.
   localparam int SETTLE_CYCLES  = 400;
   // Longest quiet stretch in a good run: a settle pause, a long sender gap
   // and a full 64-term transpose. Several times that.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_TERMS   = 240;

   // One expected transposed word.
   typedef struct packed {
      logic [COL_BITS-1:0]          row;
      logic [COL_BITS-1:0]          col;
      logic signed [VALUE_BITS-1:0] value;
      logic                         is_last;
      logic                         dropped;
   } transposed_word_type;

   // ---------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         start            = 1'b0;
   logic                         busy;
   logic [COL_BITS-1:0]          req_term_row     = '0;
   logic [COL_BITS-1:0]          req_term_col     = '0;
   logic signed [VALUE_BITS-1:0] req_term_value   = '0;
   logic                         req_last_term    = 1'b0;
   logic                         rsp_valid;
   logic [COL_BITS-1:0]          rsp_out_row;
   logic [COL_BITS-1:0]          rsp_out_col;
   logic signed [VALUE_BITS-1:0] rsp_out_value;
   logic                         rsp_out_last;
   logic                         rsp_dropped_flag;
   logic                         csr_valid        = 1'b0;
   logic                         csr_ready;
   logic [CFG_BITS-1:0]          csr_num_cols     = '0;

   // ---------------------------------------------------------------------
   // Model state
   // ---------------------------------------------------------------------
   logic [COL_BITS-1:0]          held_row   [MAX_TERMS];
   logic [COL_BITS-1:0]          held_col   [MAX_TERMS];
   logic signed [VALUE_BITS-1:0] held_value [MAX_TERMS];
   logic [CNT_BITS-1:0]          col_tally  [MAX_DIM];
   term_type                     slot_store [MAX_TERMS];
   int                           held_count   = 0;
   logic                         drop_pending = 1'b0;
   logic [CFG_BITS-1:0]          cols_in_use  = NUM_COLS_RESET;

   transposed_word_type expected_words[$];

   int   error_count  = 0;
   int   terms_sent   = 0;
   int   stall_cycles = 0;
   logic burst_mode   = 1'b0;   // no sender gaps while set

   always #HALF_PERIOD clock = ~clock;

   sparse_matrix_transpose_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_term_row     (req_term_row),
      .req_term_col     (req_term_col),
      .req_term_value   (req_term_value),
      .req_last_term    (req_last_term),
      .rsp_valid        (rsp_valid),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_last     (rsp_out_last),
      .rsp_dropped_flag (rsp_dropped_flag),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_num_cols     (csr_num_cols)
   );

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   // ---------------------------------------------------------------------
   // Model: take one accepted term; on the last one, transpose and queue
   // the words in column-major order.
   // ---------------------------------------------------------------------
   function automatic void predict_term(input logic [COL_BITS-1:0] row,
                                        input logic [COL_BITS-1:0] col,
                                        input logic signed [VALUE_BITS-1:0] value,
                                        input logic is_last);
      int                  limit;
      int                  running;
      int                  slot;
      int                  col_start [MAX_DIM];
      transposed_word_type word;

      // num_cols above the column space saturates; zero drops everything
      limit = (int'(cols_in_use) > MAX_DIM) ? MAX_DIM : int'(cols_in_use);
      if (held_count >= MAX_TERMS || int'(col) >= limit) begin
         drop_pending = 1'b1;
      end else begin
         held_row[held_count]   = row;
         held_col[held_count]   = col;
         held_value[held_count] = value;
         col_tally[col]         = col_tally[col] + 1'b1;
         held_count++;
      end
      if (!is_last) return;

      // exclusive prefix sum over the columns in use
      running = 0;
      for (int c = 0; c < MAX_DIM; c++) begin
         col_start[c] = running;
         if (c < limit) running += int'(col_tally[c]);
      end

      // scatter with row and column swapped; input order kept per column
      for (int i = 0; i < held_count; i++) begin
         slot = col_start[held_col[i]] % MAX_TERMS;
         slot_store[slot] = '{row: held_col[i], col: held_row[i], value: held_value[i]};
         col_start[held_col[i]]++;
      end

      // an all-dropped matrix yields nothing and its drop is forgotten
      for (int i = 0; i < held_count; i++) begin
         word.row     = slot_store[i].row;
         word.col     = slot_store[i].col;
         word.value   = slot_store[i].value;
         word.is_last = (i == held_count - 1);
         word.dropped = drop_pending;
         expected_words.insert(expected_words.size(), word);
      end

      foreach (col_tally[c]) col_tally[c] = '0;
      held_count   = 0;
      drop_pending = 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Result monitor: rsp_valid is a strobe, sampled at the closing edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      transposed_word_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word row %0d col %0d value %0d",
                                      rsp_out_row, rsp_out_col, rsp_out_value));
         end else begin
            want = expected_words.pop_front();
            if (rsp_out_row !== want.row)
               report_mismatch($sformatf("out_row %0d, want %0d", rsp_out_row, want.row));
            if (rsp_out_col !== want.col)
               report_mismatch($sformatf("out_col %0d, want %0d", rsp_out_col, want.col));
            if (rsp_out_value !== want.value)
               report_mismatch($sformatf("out_value %0d, want %0d",
                                         rsp_out_value, want.value));
            if (rsp_out_last !== want.is_last)
               report_mismatch($sformatf("out_last %b, want %b",
                                         rsp_out_last, want.is_last));
            if (rsp_dropped_flag !== want.dropped)
               report_mismatch($sformatf("dropped_flag %b, want %b",
                                         rsp_dropped_flag, want.dropped));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: any handshake or result word resets the count
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1 ||
          (csr_valid && csr_ready === 1'b1)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no progress in %0d cycles", $realtime, stall_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Mostly short gaps, now and then a long one; none in burst mode.
   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Send one term. start stays high on return so back-to-back words need
   // no second assignment in the same step; whoever stops sending lowers it.
   task automatic send_term(input logic [COL_BITS-1:0] row,
                            input logic [COL_BITS-1:0] col,
                            input logic signed [VALUE_BITS-1:0] value,
                            input logic is_last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_term_row   <= row;
      req_term_col   <= col;
      req_term_value <= value;
      req_last_term  <= is_last;
      do @(posedge clock); while (busy !== 1'b0);
      predict_term(row, col, value, is_last);
      terms_sent++;
   endtask

   // Stop sending, wait for every queued word, then let the unit finish any
   // work that yields no word (an all-dropped matrix, the count clear).
   task automatic wait_drained();
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the unit idle.
   task automatic write_num_cols(input logic [CFG_BITS-1:0] value);
      csr_valid    <= 1'b1;
      csr_num_cols <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid   <= 1'b0;
      cols_in_use  = value;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset setting (256 columns): field extremes, two terms in column 0 and
   // two in column 255 so order within a column shows.
   task automatic test_default_columns();
      send_term(8'd0,   8'd255, 32'sh7FFF_FFFF, 1'b0);
      send_term(8'd255, 8'd0,   32'sh8000_0000, 1'b0);
      send_term(8'd17,  8'd255, -32'sd1,        1'b0);
      send_term(8'd3,   8'd0,   32'sd0,         1'b0);
      send_term(8'd200, 8'd128, 32'sh5555_5555, 1'b1);
   endtask

   // num_cols past the column space acts as 256; single-term matrix.
   task automatic test_wide_setting();
      wait_drained();
      write_num_cols(9'd511);
      send_term(8'd42, 8'd255, -32'sd7, 1'b1);
   endtask

   // One column: out-of-range terms drop and flag every word; then a
   // matrix where all terms drop gives no word at all.
   task automatic test_column_limit();
      wait_drained();
      write_num_cols(9'd1);
      send_term(8'd9,  8'd0,   32'sd100,  1'b0);
      send_term(8'd10, 8'd1,   32'sd200,  1'b0);
      send_term(8'd11, 8'd0,   -32'sd300, 1'b1);
      send_term(8'd1,  8'd200, 32'sd5,    1'b0);
      send_term(8'd2,  8'd5,   32'sd6,    1'b1);
   endtask

   // Zero columns: every term drops.
   task automatic test_zero_columns();
      wait_drained();
      write_num_cols(9'd0);
      send_term(8'd0,   8'd0,   32'sd1, 1'b0);
      send_term(8'd255, 8'd255, 32'sd2, 1'b1);
   endtask

   // Random matrices over a series of column settings. Most are small and
   // well formed; a few overflow the term store; some terms fall outside
   // the column range.
   task automatic test_random_matrices();
      int                  base;
      int                  phase;
      int                  matrices;
      int                  size;
      int                  limit;
      int                  r;
      logic [CFG_BITS-1:0] setting;
      logic [COL_BITS-1:0] col;

      base  = terms_sent;
      phase = 0;
      while (terms_sent - base < RANDOM_TERMS) begin
         case (phase)
            0: setting = NUM_COLS_RESET;
            1: setting = 9'd1;
            2: setting = CFG_BITS'($urandom_range(2, 255));
            3: setting = 9'd511;
            4: setting = 9'd0;
            default: begin
               case ($urandom_range(0, 3))
                  0:       setting = NUM_COLS_RESET;
                  1:       setting = CFG_BITS'($urandom_range(1, 300));
                  2:       setting = CFG_BITS'($urandom_range(1, 8));
                  default: setting = 9'd511;
               endcase
            end
         endcase
         wait_drained();
         write_num_cols(setting);
         burst_mode = (phase % 3 == 2);
         limit      = (int'(setting) > MAX_DIM) ? MAX_DIM : int'(setting);
         matrices   = (setting == 0) ? 1 : $urandom_range(2, 4);

         for (int m = 0; m < matrices; m++) begin
            // first matrix of phase 2 always overflows the store
            if (phase == 2 && m == 0)           size = MAX_TERMS + 3;
            else if ($urandom_range(0, 11) == 0) size = $urandom_range(60, 70);
            else                                 size = $urandom_range(1, 10);
            for (int k = 0; k < size; k++) begin
               r = $urandom_range(0, 99);
               if (limit == 0 || (r < 10 && size <= MAX_TERMS))
                  col = COL_BITS'($urandom_range(0, 255));
               else if (r < 50)
                  col = COL_BITS'($urandom_range(0, (limit < 4 ? limit : 4) - 1));
               else
                  col = COL_BITS'($urandom_range(0, limit - 1));
               send_term(COL_BITS'($urandom_range(0, 255)), col, $urandom, k == size - 1);
            end
         end
         phase++;
      end
      burst_mode = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      foreach (col_tally[c]) col_tally[c] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_columns();
      test_wide_setting();
      test_column_limit();
      test_zero_columns();
      test_random_matrices();
      wait_drained();

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/smtu_pkg.sv
design/smtu_ram.sv
design/smtu_cnt_mem.sv
design/sparse_matrix_transpose_unit.sv
bench/tb_top.sv
